[src/me_pkg.sv]
package me_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_EXPONENT = 2'd1
  } me_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } me_state_t;

endpackage

[src/me_stream_if.sv]
interface me_msg_if #(
  parameter int unsigned WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

interface me_res_if #(
  parameter int unsigned WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

[src/modular_exponentiation.sv]
// Channel    Dir  Handshake      Payload
// in_ch      in   valid/ready    message   [WORD_BITS-1:0] unsigned
// out_ch     out  valid/ready    power_mod [WORD_BITS-1:0] unsigned
// cfg_*      in   cfg_we only    cfg_idx (0 modulus, 1 exponent), cfg_wdata
//
// Steps per beat: take the message, reduce it bit by bit, a decision step before
// every multiply or squaring and one after the last, a multiply per set exponent
// bit, a squaring per bit below the highest set one, and a hand-off of the result.
// The single interleaved add/reduce unit serves the reduction and every multiply
// and squaring, one multiplier bit per cycle.
// Reset (rst_n low, synchronous) loads modulus 1 and exponent 1 and idles.
// in_ch.ready is high only when idle; a finished result waits in the output
// register while the next beat is taken and computed.
module modular_exponentiation
  import me_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  me_msg_if.sink               in_ch,
  me_res_if.source             out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [WORD_BITS-1:0] cfg_wdata
);

  localparam int unsigned CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  me_state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] modulus_r, exponent_r;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;     // running result
  logic [WORD_BITS-1:0] base_r, base_nxt;   // running power of the message
  logic [WORD_BITS-1:0] prod_r, prod_nxt;   // working remainder of the unit
  logic [WORD_BITS-1:0] mult_r, mult_nxt;   // multiplier bits, MSB first
  logic [WORD_BITS-1:0] exp_r, exp_nxt;     // exponent bits still to scan
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_pm_r, out_pm_nxt;

  // Shared unit: prod = (2*prod + cin) mod m, then optionally (+ addend) mod m
  logic                 unit_cin, unit_add;
  logic [WORD_BITS-1:0] unit_addend, unit_out;
  logic [WORD_BITS:0]   dbl, dbl_red, sum;
  logic [WORD_BITS:0]   mod_ext;

  assign mod_ext = {1'b0, modulus_r};

  always_comb begin
    dbl     = {prod_r, unit_cin};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = dbl_red + {1'b0, (unit_add ? unit_addend : '0)};
    if (sum >= mod_ext) begin
      sum = sum - mod_ext;
    end
    unit_out = sum[WORD_BITS-1:0];
  end

  assign unit_cin    = (state_r == ST_REDUCE) ? mult_r[WORD_BITS-1] : 1'b0;
  assign unit_add    = ((state_r == ST_MUL) || (state_r == ST_SQR)) && mult_r[WORD_BITS-1];
  assign unit_addend = (state_r == ST_MUL) ? acc_r : base_r;

  // Configuration registers; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WORD_BITS'(1);
      exponent_r <= WORD_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_EXPONENT: exponent_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    base_r   <= base_nxt;
    prod_r   <= prod_nxt;
    mult_r   <= mult_nxt;
    exp_r    <= exp_nxt;
    cnt_r    <= cnt_nxt;
    out_pm_r <= out_pm_nxt;
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.power_mod = out_pm_r;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    prod_nxt      = prod_r;
    mult_nxt      = mult_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    out_pm_nxt    = out_pm_r;
    out_valid_nxt = out_valid_r;

    // Drop the result beat once the sink takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          prod_nxt = '0;
          mult_nxt = in_ch.message;
          exp_nxt  = exponent_r;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          // A zero modulus admits no reduction: answer zero at once
          state_nxt = (modulus_r == '0) ? ST_DONE : ST_REDUCE;
        end
      end

      ST_REDUCE: begin
        // Restoring reduction of the message, one bit per cycle
        prod_nxt = unit_out;
        mult_nxt = {mult_r[WORD_BITS-2:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          base_nxt  = unit_out;
          acc_nxt   = (modulus_r == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
          state_nxt = ST_STEP;
        end
      end

      ST_STEP: begin
        prod_nxt = '0;
        mult_nxt = base_r;
        cnt_nxt  = '0;
        if (exp_r == '0) begin
          state_nxt = ST_DONE;
        end else if (exp_r[0]) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SQR;
        end
      end

      ST_MUL, ST_SQR: begin
        // Interleaved shift-and-add multiply, multiplier MSB first
        prod_nxt = unit_out;
        mult_nxt = {mult_r[WORD_BITS-2:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          if (state_r == ST_MUL) begin
            acc_nxt = unit_out;
            exp_nxt = {exp_r[WORD_BITS-1:1], 1'b0};
          end else begin
            base_nxt = unit_out;
            exp_nxt  = {1'b0, exp_r[WORD_BITS-1:1]};
          end
          state_nxt = ST_STEP;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_pm_nxt    = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && modulus_r != '0) |-> (acc_r < modulus_r && base_r < modulus_r))
    else $error("operand not reduced below modulus");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result beat raised outside hand-off");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != ST_IDLE))
    else $error("accepted beat did not start work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_pm_r)))
    else $error("pending result lost");
`endif

endmodule
